FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the arm Jacobian block.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AJD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AJD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define AJD_ASSERT(lbl, prop, msg)
`define AJD_NEVER(lbl, expr, msg)
`endif
`endif

FILE: hw/rtl/ajd_pkg.sv
`default_nettype none
package ajd_pkg;

  // Joint count and CORDIC depth.
  localparam int NJ           = 5;
  localparam int CORDIC_STEPS = 24;

  // Widths of the CORDIC datapath and of the working words.
  localparam int XW = 28;
  localparam int ZW = 30;
  localparam int WW = 32;
  localparam int DW = 40;

  // Angle constants in Q.24.
  localparam logic signed [ZW-1:0] K_PI      = 30'sd52707178;
  localparam logic signed [ZW-1:0] K_HALF_PI = 30'sd26353589;
  localparam logic signed [ZW-1:0] K_TWO_PI  = 30'sd105414357;
  localparam logic signed [XW-1:0] K_GAIN    = 28'sd10188014;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'sd13176795, 30'sd7778716, 30'sd4110060, 30'sd2086331, 30'sd1047214,
    30'sd524117, 30'sd262123, 30'sd131069, 30'sd65536, 30'sd32768,
    30'sd16384, 30'sd8192, 30'sd4096, 30'sd2048, 30'sd1024, 30'sd512,
    30'sd256, 30'sd128, 30'sd64, 30'sd32, 30'sd16, 30'sd8, 30'sd4, 30'sd2
  };

  // Link lengths and unity in Q.24.
  localparam logic signed [WW-1:0] ONE_Q = 32'sd16777216;
  localparam logic signed [WW-1:0] L050  = 32'sd838861;
  localparam logic signed [WW-1:0] L025  = 32'sd419430;
  localparam logic signed [WW-1:0] L150  = 32'sd2516582;
  localparam logic signed [WW-1:0] L475  = 32'sd7969178;
  localparam logic signed [WW-1:0] L350  = 32'sd5872026;

  localparam logic signed [63:0] RND64 = 64'sd8388608;

  // Saturation limits of the Q3.28 result.
  localparam logic signed [DW-1:0] DET_HI = 40'sd134217728;
  localparam logic signed [DW-1:0] DET_LO = -40'sd134217728;
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] joint1_angle;
    logic signed [15:0] joint2_angle;
    logic signed [15:0] joint3_angle;
    logic signed [15:0] joint4_angle;
    logic signed [15:0] joint5_angle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] determinant;
    logic               saturated;
  } out_t;

  // Q.24 product, rounded to nearest with ties toward plus infinity.
  function automatic logic signed [WW-1:0] fm(input logic signed [WW-1:0] a,
                                              input logic signed [WW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + RND64;
    return p[55:24];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/arm_jacobian_determinant.sv
// Channel  | Ports                           | Transfer
// input    | start, busy, in_data (in_t)     | start high while busy low
// result   | out_strobe, out_data (out_t)    | every cycle out_strobe is high
//
// One joint vector enters in every cycle; busy stays low.
// The pipeline has one range stage, 24 CORDIC stages, one quadrant stage,
// eight multiplier stages and the output register.
// Synchronous active-low reset clears the valid bits only.
// The receiver cannot stall, so results leave as they finish.
`default_nettype none
`include "assert_macros.svh"
module arm_jacobian_determinant
  import ajd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_strobe,
  output out_t      out_data
);

  localparam int PIPE_LAT = CORDIC_STEPS + 11;
  localparam int CS       = CORDIC_STEPS;

  typedef struct packed {
    logic signed [WW-1:0] c1c3, s1c3, s1c4, c1c4, c1s3, s1s3, c3s4, c3c5;
    logic signed [WW-1:0] s3c4, s1s4, c1s4, s3c5, c3c4, t1, w, t2;
    logic signed [WW-1:0] lc1, ls1, hc1, hs1, kc2, c1, s1, s3, s4, s5;
  } m1_t;

  typedef struct packed {
    logic signed [WW-1:0] a3x, a3y, a3z, a4x, a4y, a4z, u, m1, m2, a5z;
    logic signed [WW-1:0] rw0, rw1, rw2, g0, g1, hc1, hs1, kc2, c1, s1;
  } m2_t;

  typedef struct packed {
    logic signed [WW-1:0] a3x, a3y, a3z, a4x, a4y, a4z, a5x, a5y, a5z;
    logic signed [WW-1:0] r00, r01, r10, r11, r12, r20, r21, r22, c1, ms1;
  } m3_t;

  typedef struct packed {
    logic signed [WW-1:0] d1, d2, d3, a3x, a4x, a5x, h1, k1, h4, h5;
    logic signed [WW-1:0] h6, k3, h9, h10, r12, r22, c1, ms1;
  } m4_t;

  typedef struct packed {
    logic signed [WW-1:0] fa, n1, o1, n4, o2, c1, ms1;
  } m5_t;

  typedef struct packed {
    logic signed [WW-1:0] fa, v1, v2, c1, ms1;
  } m6_t;

  typedef struct packed {
    logic signed [WW-1:0] fa, fb;
  } m7_t;

  logic [PIPE_LAT-1:0] vld_r, vld_nxt;
  logic                accept;

  logic signed [15:0]   ang [NJ];
  logic signed [XW-1:0] cx_r [NJ][CS+1];
  logic signed [XW-1:0] cx_nxt [NJ][CS+1];
  logic signed [XW-1:0] cy_r [NJ][CS+1];
  logic signed [XW-1:0] cy_nxt [NJ][CS+1];
  logic signed [ZW-1:0] cz_r [NJ][CS+1];
  logic signed [ZW-1:0] cz_nxt [NJ][CS+1];
  logic                 fl_r [NJ][CS+1];
  logic                 fl_nxt [NJ][CS+1];
  logic signed [WW-1:0] sn_r [NJ];
  logic signed [WW-1:0] sn_nxt [NJ];
  logic signed [WW-1:0] cs_r [NJ];
  logic signed [WW-1:0] cs_nxt [NJ];

  m1_t m1_r, m1_nxt;
  m2_t m2_r, m2_nxt;
  m3_t m3_r, m3_nxt;
  m4_t m4_r, m4_nxt;
  m5_t m5_r, m5_nxt;
  m6_t m6_r, m6_nxt;
  m7_t m7_r, m7_nxt;
  logic signed [DW-1:0] det_r, det_nxt;
  logic signed [63:0]   det_p;
  out_t                 out_r, out_nxt;

  // The pipeline never stalls, so a transfer happens on every start.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign ang[0] = in_data.joint1_angle;
  assign ang[1] = in_data.joint2_angle;
  assign ang[2] = in_data.joint3_angle;
  assign ang[3] = in_data.joint4_angle;
  assign ang[4] = in_data.joint5_angle;

  // Valid bits move one stage per cycle beside the data.
  assign vld_nxt = {vld_r[PIPE_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Range reduction and the CORDIC iterations that follow it.
  always_comb begin
    logic signed [ZW-1:0] z;
    // Range reduction: scale to Q.24, wrap into [-pi, pi], fold into the right half.
    for (int j = 0; j < NJ; j++) begin
      z = {{(ZW-28){ang[j][15]}}, ang[j], 12'b0};
      if (z > K_PI) z = z - K_TWO_PI;
      if (z < -K_PI) z = z + K_TWO_PI;
      fl_nxt[j][0] = 1'b0;
      if (z > K_HALF_PI) begin
        z = z - K_PI;
        fl_nxt[j][0] = 1'b1;
      end else if (z < -K_HALF_PI) begin
        z = z + K_PI;
        fl_nxt[j][0] = 1'b1;
      end
      cz_nxt[j][0] = z;
      cx_nxt[j][0] = K_GAIN;
      cy_nxt[j][0] = '0;
    end
    // One CORDIC iteration per stage; a zero residual angle rotates positive.
    for (int j = 0; j < NJ; j++) begin
      for (int i = 0; i < CS; i++) begin
        fl_nxt[j][i+1] = fl_r[j][i];
        if (!cz_r[j][i][ZW-1]) begin
          cx_nxt[j][i+1] = cx_r[j][i] - (cy_r[j][i] >>> i);
          cy_nxt[j][i+1] = cy_r[j][i] + (cx_r[j][i] >>> i);
          cz_nxt[j][i+1] = cz_r[j][i] - ATAN_TAB[i];
        end else begin
          cx_nxt[j][i+1] = cx_r[j][i] + (cy_r[j][i] >>> i);
          cy_nxt[j][i+1] = cy_r[j][i] - (cx_r[j][i] >>> i);
          cz_nxt[j][i+1] = cz_r[j][i] + ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NJ; j++) begin
      for (int i = 0; i <= CS; i++) begin
        cx_r[j][i] <= cx_nxt[j][i];
        cy_r[j][i] <= cy_nxt[j][i];
        cz_r[j][i] <= cz_nxt[j][i];
        fl_r[j][i] <= fl_nxt[j][i];
      end
    end
  end

  // Quadrant fix-up: a folded angle inverts both sine and cosine.
  always_comb begin
    for (int j = 0; j < NJ; j++) begin
      if (fl_r[j][CS]) begin
        sn_nxt[j] = -WW'(cy_r[j][CS]);
        cs_nxt[j] = -WW'(cx_r[j][CS]);
      end else begin
        sn_nxt[j] = WW'(cy_r[j][CS]);
        cs_nxt[j] = WW'(cx_r[j][CS]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NJ; j++) begin
      sn_r[j] <= sn_nxt[j];
      cs_r[j] <= cs_nxt[j];
    end
  end

  // First products of the trig terms and the linear wrist sums.
  always_comb begin
    m1_nxt.c1c3 = fm(cs_r[0], cs_r[2]);
    m1_nxt.s1c3 = fm(sn_r[0], cs_r[2]);
    m1_nxt.s1c4 = fm(sn_r[0], cs_r[3]);
    m1_nxt.c1c4 = fm(cs_r[0], cs_r[3]);
    m1_nxt.c1s3 = fm(cs_r[0], sn_r[2]);
    m1_nxt.s1s3 = fm(sn_r[0], sn_r[2]);
    m1_nxt.c3s4 = fm(cs_r[2], sn_r[3]);
    m1_nxt.c3c5 = fm(cs_r[2], cs_r[4]);
    m1_nxt.s3c4 = fm(sn_r[2], cs_r[3]);
    m1_nxt.s1s4 = fm(sn_r[0], sn_r[3]);
    m1_nxt.c1s4 = fm(cs_r[0], sn_r[3]);
    m1_nxt.s3c5 = fm(sn_r[2], cs_r[4]);
    m1_nxt.c3c4 = fm(cs_r[2], cs_r[3]);
    m1_nxt.t1 = ONE_Q * 32'sd3 + (sn_r[1] + cs_r[2]) * 32'sd7 + sn_r[2] * 32'sd2;
    m1_nxt.w  = ONE_Q * 32'sd19 + (cs_r[1] - sn_r[2]) * 32'sd14 + cs_r[2] * 32'sd4;
    m1_nxt.t2 = ONE_Q * 32'sd3 + sn_r[1] * 32'sd7;
    m1_nxt.lc1 = fm(L050, cs_r[0]);
    m1_nxt.ls1 = fm(L050, sn_r[0]);
    m1_nxt.hc1 = fm(L150, cs_r[0]);
    m1_nxt.hs1 = fm(L150, sn_r[0]);
    m1_nxt.kc2 = fm(L350, cs_r[1]);
    m1_nxt.c1 = cs_r[0];
    m1_nxt.s1 = sn_r[0];
    m1_nxt.s3 = sn_r[2];
    m1_nxt.s4 = sn_r[3];
    m1_nxt.s5 = sn_r[4];
  end

  // Wrist axes and the wrist position.
  always_comb begin
    m2_nxt.a3x = m1_r.c1c3;
    m2_nxt.a3y = m1_r.s1c3;
    m2_nxt.a3z = -m1_r.s3;
    m2_nxt.a4x = fm(m1_r.c1s3, m1_r.s4) - m1_r.s1c4;
    m2_nxt.a4y = m1_r.c1c4 + fm(m1_r.s1s3, m1_r.s4);
    m2_nxt.a4z = m1_r.c3s4;
    m2_nxt.u   = m1_r.c3c5 - fm(m1_r.s3c4, m1_r.s5);
    m2_nxt.m1  = fm(m1_r.s1s4, m1_r.s5);
    m2_nxt.m2  = fm(m1_r.c1s4, m1_r.s5);
    m2_nxt.a5z = -m1_r.s3c5 - fm(m1_r.c3c4, m1_r.s5);
    m2_nxt.rw0 = fm(m1_r.lc1, m1_r.t1);
    m2_nxt.rw1 = fm(m1_r.ls1, m1_r.t1);
    m2_nxt.rw2 = fm(L025, m1_r.w);
    m2_nxt.g0  = fm(m1_r.lc1, m1_r.t2);
    m2_nxt.g1  = fm(m1_r.ls1, m1_r.t2);
    m2_nxt.hc1 = m1_r.hc1;
    m2_nxt.hs1 = m1_r.hs1;
    m2_nxt.kc2 = m1_r.kc2;
    m2_nxt.c1  = m1_r.c1;
    m2_nxt.s1  = m1_r.s1;
  end

  // Last wrist axis and the position vectors relative to the wrist.
  always_comb begin
    m3_nxt.a3x = m2_r.a3x;
    m3_nxt.a3y = m2_r.a3y;
    m3_nxt.a3z = m2_r.a3z;
    m3_nxt.a4x = m2_r.a4x;
    m3_nxt.a4y = m2_r.a4y;
    m3_nxt.a4z = m2_r.a4z;
    m3_nxt.a5x = fm(m2_r.c1, m2_r.u) - m2_r.m1;
    m3_nxt.a5y = m2_r.m2 + fm(m2_r.s1, m2_r.u);
    m3_nxt.a5z = m2_r.a5z;
    m3_nxt.r00 = -m2_r.rw0;
    m3_nxt.r01 = -m2_r.rw1;
    m3_nxt.r10 = m2_r.hc1 - m2_r.rw0;
    m3_nxt.r11 = m2_r.hs1 - m2_r.rw1;
    m3_nxt.r12 = L475 - m2_r.rw2;
    m3_nxt.r20 = m2_r.g0 - m2_r.rw0;
    m3_nxt.r21 = m2_r.g1 - m2_r.rw1;
    m3_nxt.r22 = L475 + m2_r.kc2 - m2_r.rw2;
    m3_nxt.c1  = m2_r.c1;
    m3_nxt.ms1 = -m2_r.s1;
  end

  // Cross-product terms of both triple products.
  always_comb begin
    m4_nxt.d1  = fm(m3_r.a4y, m3_r.a5z) - fm(m3_r.a5y, m3_r.a4z);
    m4_nxt.d2  = fm(m3_r.a3y, m3_r.a5z) - fm(m3_r.a5y, m3_r.a3z);
    m4_nxt.d3  = fm(m3_r.a3y, m3_r.a4z) - fm(m3_r.a4y, m3_r.a3z);
    m4_nxt.a3x = m3_r.a3x;
    m4_nxt.a4x = m3_r.a4x;
    m4_nxt.a5x = m3_r.a5x;
    m4_nxt.h1  = fm(m3_r.c1, m3_r.r00);
    m4_nxt.k1  = fm(m3_r.r20, m3_r.r12) - fm(m3_r.r10, m3_r.r22);
    m4_nxt.h4  = fm(m3_r.r10, m3_r.r01);
    m4_nxt.h5  = fm(m3_r.r00, m3_r.r21);
    m4_nxt.h6  = fm(m3_r.ms1, m3_r.r01);
    m4_nxt.k3  = fm(m3_r.r21, m3_r.r12) - fm(m3_r.r11, m3_r.r22);
    m4_nxt.h9  = fm(m3_r.r00, m3_r.r11);
    m4_nxt.h10 = fm(m3_r.r20, m3_r.r01);
    m4_nxt.r12 = m3_r.r12;
    m4_nxt.r22 = m3_r.r22;
    m4_nxt.c1  = m3_r.c1;
    m4_nxt.ms1 = m3_r.ms1;
  end

  // Wrist triple product and the inner terms of the arm part.
  always_comb begin
    m5_nxt.fa  = fm(m4_r.a3x, m4_r.d1) - fm(m4_r.a4x, m4_r.d2) + fm(m4_r.a5x, m4_r.d3);
    m5_nxt.n1  = fm(m4_r.h1, m4_r.k1);
    m5_nxt.o1  = fm(m4_r.h4, m4_r.r22) - fm(m4_r.h5, m4_r.r12);
    m5_nxt.n4  = fm(m4_r.h6, m4_r.k3);
    m5_nxt.o2  = fm(m4_r.h9, m4_r.r22) - fm(m4_r.h10, m4_r.r12);
    m5_nxt.c1  = m4_r.c1;
    m5_nxt.ms1 = m4_r.ms1;
  end

  always_comb begin
    m6_nxt.fa  = m5_r.fa;
    m6_nxt.v1  = m5_r.n1 + fm(m5_r.ms1, m5_r.o1);
    m6_nxt.v2  = m5_r.n4 + fm(m5_r.c1, m5_r.o2);
    m6_nxt.c1  = m5_r.c1;
    m6_nxt.ms1 = m5_r.ms1;
  end

  always_comb begin
    m7_nxt.fa = m6_r.fa;
    m7_nxt.fb = fm(m6_r.c1, m6_r.v1) + fm(m6_r.ms1, m6_r.v2);
  end

  // Final product kept at 40 bits so that overflow can be seen.
  always_comb begin
    det_p   = 64'(m7_r.fa) * 64'(m7_r.fb) + RND64;
    det_nxt = det_p[63:24];
  end

  // Saturate into Q3.28.
  always_comb begin
    if (det_r >= DET_HI) begin
      out_nxt.determinant = SAT_POS;
      out_nxt.saturated   = 1'b1;
    end else if (det_r < DET_LO) begin
      out_nxt.determinant = SAT_NEG;
      out_nxt.saturated   = 1'b1;
    end else begin
      out_nxt.determinant = {det_r[27:0], 4'b0};
      out_nxt.saturated   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    m1_r  <= m1_nxt;
    m2_r  <= m2_nxt;
    m3_r  <= m3_nxt;
    m4_r  <= m4_nxt;
    m5_r  <= m5_nxt;
    m6_r  <= m6_nxt;
    m7_r  <= m7_nxt;
    det_r <= det_nxt;
    out_r <= out_nxt;
  end

  assign out_strobe = vld_r[PIPE_LAT-1];
  assign out_data   = out_r;

  // Checks on latency, on the saturation encoding, on the zero low bits and on busy staying low.
  `AJD_ASSERT(a_latency, accept |-> ##35 out_strobe, "result missing after latency")
  `AJD_ASSERT(a_sat_code, out_strobe && out_data.saturated |->
    (out_data.determinant == SAT_POS || out_data.determinant == SAT_NEG), "bad clip code")
  `AJD_ASSERT(a_low_bits, out_strobe && !out_data.saturated |->
    out_data.determinant[3:0] == 4'b0, "nonzero low bits")
  `AJD_NEVER(a_no_busy, busy, "busy raised")

endmodule
`default_nettype wire
